>>> rtl/lnedit_pkg.sv
// Line editor package: result kinds, register indexes, character codes,
// the pending-request type handed from decode to the output sequencer.
// No dependencies.
`default_nettype none

package lnedit_pkg;

  localparam int unsigned LINE_DEPTH_DEF = 256;
  localparam int unsigned CHAR_W         = 8;
  localparam int unsigned LEN_W          = 8;

  localparam logic [7:0] MAX_LEN_RST = 8'd64;
  localparam logic       ECHO_EN_RST = 1'b1;

  // register indexes
  localparam logic REG_MAX_LEN = 1'b0;
  localparam logic REG_ECHO_EN = 1'b1;

  // operations
  localparam logic OP_RX   = 1'b0;
  localparam logic OP_READ = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_ECHO = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  // characters
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_NUL   = 8'h00;

  typedef enum logic [2:0] {
    JOB_READ,
    JOB_DONE,
    JOB_ECHO,
    JOB_ECHO_DONE,
    JOB_BS
  } job_kind_e;

  // one accepted request's pending results
  typedef struct packed {
    job_kind_e         kind;
    logic [CHAR_W-1:0] ch;
    logic [LEN_W-1:0]  len;
    logic              hit;  // read index below length
  } job_t;

endpackage

`default_nettype wire

>>> rtl/lnedit_store.sv
// Line editor character store: one write port, one registered read port.
// Depends on nothing; sized by the top level.
`default_nettype none

module lnedit_store #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = $clog2(DEPTH),
  parameter int unsigned DW    = 8
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/line_editor_with_echo_top.sv
// Line editor with echo, top level: decode, line state, output sequencer.
// Depends on lnedit_pkg and lnedit_store.
`default_nettype none

// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one request: operation_i
//   selects receive (rx_char_i) or read (read_index_i). Output channel
//   (out_valid_o/out_ready_i) carries results; last_o marks the final result
//   of a request. A request gives zero to three results.
//   Line state and the store are updated at the accepting edge, so the next
//   request may follow in the next cycle. Results appear in the cycle after
//   acceptance and leave one per cycle while out_ready_i is high; the output
//   register holds them until the last is taken, and the next request is taken
//   in the cycle its predecessor's last result is taken. The single output
//   register sets the sustained request rate.
//   Read data comes from the store's registered read port.
//   Reset empties the line (length 0, open) and sets max_len 64, echo on;
//   store contents are undefined until written. If the receiver stalls, the
//   current result holds and in_ready_o drops until the last pending result
//   is taken. The user must write configuration only while idle, through
//   cfg_we_i/cfg_addr_i/cfg_wdata_i; the block does not enforce this.

module line_editor_with_echo_top #(
  parameter int unsigned LINE_DEPTH = lnedit_pkg::LINE_DEPTH_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_addr_i,
  input  wire logic [7:0] cfg_wdata_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic       operation_i,
  input  wire logic [7:0] rx_char_i,
  input  wire logic [7:0] read_index_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic      [1:0] result_kind_o,
  output logic      [7:0] byte_out_o,
  output logic      [7:0] line_length_o,
  output logic            last_o
);

  localparam int unsigned AW       = $clog2(LINE_DEPTH);
  localparam logic [7:0]  LAST_IDX = 8'(LINE_DEPTH - 1);

  logic [7:0] max_len_q;
  logic       echo_en_q;
  logic [7:0] count_q, count_d;
  logic       closed_q, closed_d;

  lnedit_pkg::job_t job_q, job_d;
  logic             job_valid_q, job_valid_d;
  logic [1:0]       step_q, step_d;
  logic             job_load;

  logic [7:0] lim_raw, lim, cnt0, cnt1;
  logic       accept, printable, wr_en, rd_en, at_last, adv, fin;
  logic [7:0] rdata;

  // config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= lnedit_pkg::MAX_LEN_RST;
      echo_en_q <= lnedit_pkg::ECHO_EN_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        lnedit_pkg::REG_MAX_LEN: max_len_q <= cfg_wdata_i;
        lnedit_pkg::REG_ECHO_EN: echo_en_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign lim_raw   = (max_len_q == 8'd0) ? 8'd0 : max_len_q - 8'd1;
  assign lim       = (lim_raw > LAST_IDX) ? LAST_IDX : lim_raw;
  assign cnt0      = closed_q ? 8'd0 : count_q;
  assign cnt1      = cnt0 + 8'd1;
  assign printable = (rx_char_i >= lnedit_pkg::CH_SPACE) &&
                     (rx_char_i <= lnedit_pkg::CH_TILDE);

  assign adv        = job_valid_q && out_ready_i;
  assign fin        = adv && at_last;
  assign in_ready_o = !job_valid_q || fin;
  assign accept     = in_valid_i && in_ready_o;

  // decode and line state update
  always_comb begin
    count_d     = count_q;
    closed_d    = closed_q;
    job_load    = 1'b0;
    job_d       = job_q;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    if (accept) begin
      if (operation_i == lnedit_pkg::OP_READ) begin
        rd_en     = 1'b1;
        job_load  = 1'b1;
        job_d.kind = lnedit_pkg::JOB_READ;
        job_d.ch  = lnedit_pkg::CH_NUL;
        job_d.len = count_q;
        job_d.hit = read_index_i < count_q;
      end else begin
        count_d  = cnt0;
        closed_d = 1'b0;
        job_d.ch  = rx_char_i;
        job_d.hit = 1'b0;
        job_d.len = cnt0;
        if (cnt0 >= lim || rx_char_i == lnedit_pkg::CH_LF ||
            rx_char_i == lnedit_pkg::CH_CR) begin
          closed_d   = 1'b1;
          job_load   = 1'b1;
          job_d.kind = lnedit_pkg::JOB_DONE;
        end else if (printable) begin
          wr_en     = 1'b1;
          count_d   = cnt1;
          job_d.len = cnt1;
          if (cnt1 >= lim) begin
            closed_d   = 1'b1;
            job_load   = 1'b1;
            job_d.kind = echo_en_q ? lnedit_pkg::JOB_ECHO_DONE : lnedit_pkg::JOB_DONE;
          end else begin
            job_load   = echo_en_q;
            job_d.kind = lnedit_pkg::JOB_ECHO;
          end
        end else if (rx_char_i == lnedit_pkg::CH_BS && cnt0 != 8'd0) begin
          count_d    = cnt0 - 8'd1;
          job_d.len  = cnt0 - 8'd1;
          job_load   = echo_en_q;
          job_d.kind = lnedit_pkg::JOB_BS;
        end
      end
    end
  end

  lnedit_store #(
    .DEPTH (LINE_DEPTH),
    .AW    (AW),
    .DW    (lnedit_pkg::CHAR_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (cnt0[AW-1:0]),
    .wdata_i (rx_char_i),
    .re_i    (rd_en),
    .raddr_i (read_index_i[AW-1:0]),
    .rdata_o (rdata)
  );

  // output sequencer
  always_comb begin
    case (job_q.kind)
      lnedit_pkg::JOB_ECHO_DONE: at_last = (step_q == 2'd1);
      lnedit_pkg::JOB_BS:        at_last = (step_q == 2'd2);
      default:                   at_last = 1'b1;
    endcase
  end

  always_comb begin
    job_valid_d = job_valid_q;
    step_d      = step_q;
    if (job_load) begin
      job_valid_d = 1'b1;
      step_d      = 2'd0;
    end else if (fin) begin
      job_valid_d = 1'b0;
    end else if (adv) begin
      step_d = step_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= 8'd0;
      closed_q    <= 1'b0;
      job_valid_q <= 1'b0;
      step_q      <= 2'd0;
    end else begin
      count_q     <= count_d;
      closed_q    <= closed_d;
      job_valid_q <= job_valid_d;
      step_q      <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_load) begin
      job_q <= job_d;
    end
  end

  always_comb begin
    result_kind_o = lnedit_pkg::KIND_ECHO;
    byte_out_o    = job_q.ch;
    case (job_q.kind)
      lnedit_pkg::JOB_READ: begin
        result_kind_o = lnedit_pkg::KIND_READ;
        byte_out_o    = job_q.hit ? rdata : lnedit_pkg::CH_NUL;
      end
      lnedit_pkg::JOB_DONE: begin
        result_kind_o = lnedit_pkg::KIND_DONE;
        byte_out_o    = lnedit_pkg::CH_NUL;
      end
      lnedit_pkg::JOB_ECHO_DONE: begin
        if (step_q != 2'd0) begin
          result_kind_o = lnedit_pkg::KIND_DONE;
          byte_out_o    = lnedit_pkg::CH_NUL;
        end
      end
      lnedit_pkg::JOB_BS: begin
        byte_out_o = (step_q == 2'd1) ? lnedit_pkg::CH_SPACE : lnedit_pkg::CH_BS;
      end
      default: ;
    endcase
  end

  assign out_valid_o   = job_valid_q;
  assign line_length_o = job_q.len;
  assign last_o        = at_last;

endmodule

`default_nettype wire

>>> dv/testbench.sv
`timescale 1ns / 1ps
// Testbench for line_editor_with_echo_top: directed and random requests, checked
// against a scoreboard that models the line state. Depends on lnedit_pkg and the RTL.

typedef struct packed {
  logic [1:0] kind;
  logic [7:0] data;
  logic [7:0] len;
  logic       last;
} line_result_t;

class line_scoreboard;
  logic [7:0]   max_len;
  logic         echo_on;
  int unsigned  count;
  bit           closed;
  logic [7:0]   store [256];
  line_result_t expected [$];
  int           errors;
  int           requests;
  int           results;
  int           lines;

  function new();
    max_len  = lnedit_pkg::MAX_LEN_RST;
    echo_on  = lnedit_pkg::ECHO_EN_RST;
    count    = 0;
    closed   = 0;
    errors   = 0;
    requests = 0;
    results  = 0;
    lines    = 0;
  endfunction

  function void write_reg(logic addr, logic [7:0] value);
    if (addr == lnedit_pkg::REG_MAX_LEN) begin
      max_len = value;
    end else begin
      echo_on = value[0];
    end
  endfunction

  function void push(logic [1:0] kind, logic [7:0] data);
    line_result_t r;
    r.kind = kind;
    r.data = data;
    r.len  = count[7:0];
    r.last = 1'b0;
    expected.push_back(r);
  endfunction

  function void close_line();
    closed = 1;
    lines++;
    push(lnedit_pkg::KIND_DONE, lnedit_pkg::CH_NUL);
  endfunction

  function void note_request(logic op, logic [7:0] ch, logic [7:0] idx);
    int unsigned lim;
    int          first;
    first = expected.size();
    requests++;
    if (op == lnedit_pkg::OP_READ) begin
      push(lnedit_pkg::KIND_READ, (idx < count) ? store[idx] : lnedit_pkg::CH_NUL);
    end else begin
      if (closed) begin
        closed = 0;
        count  = 0;
      end
      lim = (max_len > 0) ? int'(max_len) - 1 : 0;
      if (count >= lim) begin
        // limit already reached: byte dropped, line closes
        close_line();
      end else if (ch == lnedit_pkg::CH_LF || ch == lnedit_pkg::CH_CR) begin
        close_line();
      end else if (ch >= lnedit_pkg::CH_SPACE && ch <= lnedit_pkg::CH_TILDE) begin
        store[count] = ch;
        count++;
        if (echo_on) push(lnedit_pkg::KIND_ECHO, ch);
        if (count >= lim) close_line();
      end else if (ch == lnedit_pkg::CH_BS && count > 0) begin
        count--;
        if (echo_on) begin
          push(lnedit_pkg::KIND_ECHO, lnedit_pkg::CH_BS);
          push(lnedit_pkg::KIND_ECHO, lnedit_pkg::CH_SPACE);
          push(lnedit_pkg::KIND_ECHO, lnedit_pkg::CH_BS);
        end
      end
    end
    if (expected.size() > first) expected[expected.size() - 1].last = 1'b1;
  endfunction

  function void mismatch(string what, logic [7:0] want_v, logic [7:0] got_v);
    errors++;
    $display("%0t: %s mismatch, expected %h, got %h", $time, what, want_v, got_v);
  endfunction

  function void check_result(line_result_t got);
    line_result_t want;
    results++;
    if (expected.size() == 0) begin
      errors++;
      $display("%0t: result with nothing pending, expected none, got kind %0d byte %h len %0d",
               $time, got.kind, got.data, got.len);
      return;
    end
    want = expected.pop_front();
    if (got.kind !== want.kind) mismatch("result_kind", {6'd0, want.kind}, {6'd0, got.kind});
    if (got.data !== want.data) mismatch("byte_out", want.data, got.data);
    if (got.len !== want.len) mismatch("line_length", want.len, got.len);
    if (got.last !== want.last) mismatch("last", {7'd0, want.last}, {7'd0, got.last});
  endfunction
endclass

module testbench;

  localparam int MAX_CYCLES    = 200000;
  localparam int HOLD_CYCLES   = 80;
  localparam int SETTLE_CYCLES = 4;

  logic       clk_i;
  logic       rst_ni       = 1'b0;
  logic       cfg_we_i     = 1'b0;
  logic       cfg_addr_i   = 1'b0;
  logic [7:0] cfg_wdata_i  = 8'h00;
  logic       in_valid_i   = 1'b0;
  logic       in_ready_o;
  logic       operation_i  = 1'b0;
  logic [7:0] rx_char_i    = 8'h00;
  logic [7:0] read_index_i = 8'h00;
  logic       out_valid_o;
  logic       out_ready_i  = 1'b0;
  logic [1:0] result_kind_o;
  logic [7:0] byte_out_o;
  logic [7:0] line_length_o;
  logic       last_o;

  line_scoreboard sb = new();

  bit          no_idle      = 0;
  int          stall_asked  = 0;
  int          stall_served = 0;
  int          hold_left    = 0;
  int          settings     = 0;
  int unsigned cycles       = 0;

  line_editor_with_echo_top dut (.*);

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // result side: check, then pick next ready
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        sb.check_result({result_kind_o, byte_out_o, line_length_o, last_o});
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (stall_asked != stall_served) begin
        stall_served++;
        hold_left = HOLD_CYCLES;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= no_idle || ($urandom_range(0, 99) >= 28);
      end
    end
  end

  task automatic send(logic op, logic [7:0] ch, logic [7:0] idx);
    while (!no_idle && $urandom_range(0, 99) < 28) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    operation_i  <= op;
    rx_char_i    <= ch;
    read_index_i <= idx;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(op, ch, idx);
  endtask

  task automatic rx(logic [7:0] ch);
    send(lnedit_pkg::OP_RX, ch, 8'($urandom_range(0, 255)));
  endtask

  task automatic rd(logic [7:0] idx);
    send(lnedit_pkg::OP_READ, 8'($urandom_range(0, 255)), idx);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.expected.size() != 0) @(negedge clk_i);
    @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic configure(logic [7:0] max_len, logic echo);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= lnedit_pkg::REG_MAX_LEN;
    cfg_wdata_i <= max_len;
    @(posedge clk_i);
    cfg_addr_i  <= lnedit_pkg::REG_ECHO_EN;
    cfg_wdata_i <= {7'b0, echo};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(lnedit_pkg::REG_MAX_LEN, max_len);
    sb.write_reg(lnedit_pkg::REG_ECHO_EN, {7'b0, echo});
    settings++;
  endtask

  initial begin
    int         pick;
    int         hi;
    logic [7:0] ch;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: echo, backspace, ignored bytes, reads, close and reopen
    rx(8'h41);
    rx(8'h62);
    rd(8'd0);
    rd(8'd2);
    rd(8'd255);
    rx(lnedit_pkg::CH_BS);
    rx(lnedit_pkg::CH_BS);
    rx(lnedit_pkg::CH_BS);
    rx(lnedit_pkg::CH_SPACE);
    rx(lnedit_pkg::CH_TILDE);
    rx(8'h1F);
    rx(8'h7F);
    rx(8'h80);
    rx(8'hFF);
    rx(lnedit_pkg::CH_NUL);
    rx(lnedit_pkg::CH_CR);
    rd(8'd1);
    rx(lnedit_pkg::CH_CR);
    rx(lnedit_pkg::CH_LF);
    rx(8'h5A);

    // echo off, limit reached by a printable byte
    settle();
    configure(8'd4, 1'b0);
    rx(8'h70);
    rx(lnedit_pkg::CH_BS);
    rx(8'h71);
    rx(8'h72);

    // smallest buffer: every printable byte closes the line
    settle();
    configure(8'd2, 1'b1);
    rx(8'h78);

    // limit lowered under an open line
    settle();
    configure(8'd12, 1'b1);
    rx(8'h68);
    rx(8'h65);
    rx(8'h79);
    settle();
    configure(8'd3, 1'b1);
    rx(8'h79);
    rd(8'd2);

    for (int p = 0; p < 4; p++) begin
      settle();
      case (p)
        0: configure(8'd255, 1'b1);
        1: configure(8'd9, 1'b1);
        2: configure(8'd3, 1'b0);
        default: configure(8'($urandom_range(2, 40)), 1'($urandom_range(0, 1)));
      endcase
      no_idle = (p == 0);
      if (p == 1) stall_asked++;
      repeat (20) begin
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          hi = (sb.count + 1 > 255) ? 255 : sb.count + 1;
          rd(8'($urandom_range(0, 1) ? $urandom_range(0, hi) : $urandom_range(0, 255)));
        end else begin
          if (pick < 70) begin
            ch = 8'($urandom_range(lnedit_pkg::CH_SPACE, lnedit_pkg::CH_TILDE));
          end else if (pick < 82) begin
            ch = lnedit_pkg::CH_BS;
          end else if (pick < 90) begin
            ch = $urandom_range(0, 1) ? lnedit_pkg::CH_CR : lnedit_pkg::CH_LF;
          end else if (pick < 95) begin
            ch = 8'($urandom_range(0, 8'h1F));
          end else begin
            ch = 8'($urandom_range(8'h7F, 8'hFF));
          end
          rx(ch);
        end
      end
    end
    no_idle = 0;
    settle();

    $display("Covered %0d requests, %0d results and %0d closed lines over %0d settings,",
             sb.requests, sb.results, sb.lines, settings);
    $display("with echo on and off, max_len 2 to 255 and one %0d-cycle output stall.",
             HOLD_CYCLES);
    if (sb.errors == 0 && sb.expected.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end
endmodule

>>> line_editor_with_echo_top.f
rtl/lnedit_pkg.sv
rtl/lnedit_store.sv
rtl/line_editor_with_echo_top.sv
dv/testbench.sv
